@@ sv/dual_threshold_trigger_primitive_macros.svh @@
// Assertion macros for the dual threshold trigger primitive block.
// Used by the top level; expects clk and rst in scope.
`ifndef DUAL_THRESHOLD_TRIGGER_PRIMITIVE_MACROS_SVH
`define DUAL_THRESHOLD_TRIGGER_PRIMITIVE_MACROS_SVH

// same-cycle implication
`define DTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dtt_pkg.sv @@
// Shared types and constants for the dual threshold trigger primitive block.
// No dependencies.
package dtt_pkg;

  localparam int TICK_SHIFT = 6;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int TICK_W   = 32;
  localparam int COUNT_W  = 13;
  localparam int POST_W   = 12;
  localparam int OFFSET_W = 8;
  localparam int WNUM_W   = 16;

  localparam int S_DATA_W   = 56;
  localparam int M_DATA_W   = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic signed [SAMPLE_W-1:0] LOW_LEVEL_RST  = -16'sd150;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LEVEL_RST = -16'sd350;
  localparam logic [POST_W-1:0]          POST_RST       = 12'd742;
  localparam logic [OFFSET_W-1:0]        OFFSET_RST     = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_LEVEL   = 3'd0,
    REG_HIGH_LEVEL  = 3'd1,
    REG_POST_WINDOW = 3'd2,
    REG_TICK_OFFSET = 3'd3,
    REG_XT_ENABLE   = 3'd4,
    REG_SPARE_EN    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low_level;
    logic signed [SAMPLE_W-1:0] high_level;
    logic [POST_W-1:0]          post_window;
    logic [OFFSET_W-1:0]        tick_offset;
    logic                       xt_enable;
    logic                       spare_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]          sample_time;
    logic                       start_of_signal;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              two;
    logic              single_ht;
    logic [TICK_W-1:0] tick0;
    logic [TICK_W-1:0] tick1;
    logic [WNUM_W-1:0] wnum;
  } event_t;

endpackage

@@ sv/dtt_window.sv @@
// Window tracking for the trigger primitive block: thresholds, ticks, closing.
// Depends on dtt_pkg.
module dtt_window
  import dtt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  item_t  item,
  input  cfg_t   cfg,
  output event_t ev
);

  logic              window_open, window_open_next;
  logic              high_seen, high_seen_next;
  logic [COUNT_W-1:0] samples_since_low, samples_since_low_next;
  logic [TICK_W-1:0] low_tick, low_tick_next;
  logic [TICK_W-1:0] high_tick, high_tick_next;
  logic [WNUM_W-1:0] window_counter, window_counter_next;

  logic [TICK_W:0]   tick_sum;
  logic [TICK_W-1:0] tick;

  assign tick_sum = {1'b0, TICK_W'(item.sample_time >> TICK_SHIFT)}
                  + {{(TICK_W + 1 - OFFSET_W){1'b0}}, cfg.tick_offset};
  assign tick = tick_sum[TICK_W] ? '1 : tick_sum[TICK_W-1:0];

  always_comb begin
    window_open_next       = window_open;
    high_seen_next         = high_seen;
    samples_since_low_next = samples_since_low;
    low_tick_next          = low_tick;
    high_tick_next         = high_tick;
    window_counter_next    = window_counter;
    ev                     = '0;

    if (item.start_of_signal) begin
      window_open_next       = 1'b0;
      high_seen_next         = 1'b0;
      samples_since_low_next = '0;
      low_tick_next          = '0;
      high_tick_next         = '0;
    end

    if (!window_open_next && (item.sample_value <= cfg.low_level)) begin
      window_open_next       = 1'b1;
      high_seen_next         = 1'b0;
      samples_since_low_next = '0;
      low_tick_next          = tick;
      high_tick_next         = '0;
    end

    if (window_open_next && !high_seen_next && (item.sample_value <= cfg.high_level)) begin
      high_seen_next = 1'b1;
      high_tick_next = tick;
    end

    if (window_open_next) begin
      if (samples_since_low_next >= {1'b0, cfg.post_window}) begin
        ev.valid     = 1'b1;
        ev.two       = high_seen_next && (high_tick_next != low_tick_next);
        ev.single_ht = high_seen_next && (high_tick_next == low_tick_next);
        ev.tick0     = low_tick_next;
        ev.tick1     = high_tick_next;
        ev.wnum      = window_counter;
        window_counter_next    = window_counter + 1'b1;
        window_open_next       = 1'b0;
        high_seen_next         = 1'b0;
        samples_since_low_next = '0;
        low_tick_next          = '0;
        high_tick_next         = '0;
      end else if (samples_since_low_next != COUNT_MAX) begin
        samples_since_low_next = samples_since_low_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_open       <= 1'b0;
      high_seen         <= 1'b0;
      samples_since_low <= '0;
      low_tick          <= '0;
      high_tick         <= '0;
      window_counter    <= '0;
    end else if (fire) begin
      window_open       <= window_open_next;
      high_seen         <= high_seen_next;
      samples_since_low <= samples_since_low_next;
      low_tick          <= low_tick_next;
      high_tick         <= high_tick_next;
      window_counter    <= window_counter_next;
    end
  end

endmodule

@@ sv/dual_threshold_trigger_primitive.sv @@
// Top level of the dual threshold trigger primitive block.
// Depends on dtt_pkg, dtt_window and dual_threshold_trigger_primitive_macros.svh.
//
// Usage:
//   Samples enter on the s_ stream, one item per sample. Trigger primitives
//   leave on the m_ stream; m_tlast marks the final primitive of a sample.
//   Thresholds and window settings are written through cfg_we / cfg_index /
//   cfg_data while the block is idle; unknown indexes are ignored.
//   Path: a sample waits in the input register until the window update takes
//   it, then its primitives are held in the result register until taken.
//   Throughput: one sample per cycle unless a closing sample waits on output.
//   A window closing with separate low and high ticks gives two primitives,
//   both held in the result register until taken; if the input register's
//   sample also closes a window, it waits until the second one is taken.
//   Reset: configuration returns to its defaults, the window is closed and
//   the window number restarts at zero.
//   Stall: while m_tready is low the result register holds, and s_tready
//   drops once a waiting sample would produce a primitive.
`include "dual_threshold_trigger_primitive_macros.svh"

module dual_threshold_trigger_primitive
  import dtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sample_value[15:0], sample_time[47:16], start_of_signal[48], zero pad
  input  logic [S_DATA_W-1:0]   s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tp_tick[31:0], lto_flag[32], ht_count[33], xt_flag[34], spare_flag[35],
  // window_number[51:36], zero pad
  output logic [M_DATA_W-1:0]   m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  item_t  a_item;
  logic   a_valid;
  logic   a_adv;
  event_t core_ev;
  event_t ev;
  logic   ev_valid;
  logic   ev_phase;
  logic   ev_free;
  logic   lto_out;
  logic   ht_out;
  logic [TICK_W-1:0] tick_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_level    <= LOW_LEVEL_RST;
      cfg.high_level   <= HIGH_LEVEL_RST;
      cfg.post_window  <= POST_RST;
      cfg.tick_offset  <= OFFSET_RST;
      cfg.xt_enable    <= 1'b0;
      cfg.spare_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LEVEL:   cfg.low_level    <= cfg_data;
        REG_HIGH_LEVEL:  cfg.high_level   <= cfg_data;
        REG_POST_WINDOW: cfg.post_window  <= cfg_data[POST_W-1:0];
        REG_TICK_OFFSET: cfg.tick_offset  <= cfg_data[OFFSET_W-1:0];
        REG_XT_ENABLE:   cfg.xt_enable    <= cfg_data[0];
        REG_SPARE_EN:    cfg.spare_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ev_free  = !ev_valid || (m_tready && (!ev.two || ev_phase));
  assign a_adv    = a_valid && (!core_ev.valid || ev_free);
  assign s_tready = !a_valid || a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_item.sample_value    <= s_tdata[SAMPLE_W-1:0];
      a_item.sample_time     <= s_tdata[SAMPLE_W +: TIME_W];
      a_item.start_of_signal <= s_tdata[SAMPLE_W + TIME_W];
    end
  end

  dtt_window u_window (
    .clk  (clk),
    .rst  (rst),
    .fire (a_adv),
    .item (a_item),
    .cfg  (cfg),
    .ev   (core_ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
      ev_phase <= 1'b0;
    end else if (a_adv && core_ev.valid) begin
      ev_valid <= 1'b1;
      ev_phase <= 1'b0;
    end else if (ev_valid && m_tready) begin
      if (ev.two && !ev_phase) begin
        ev_phase <= 1'b1;
      end else begin
        ev_valid <= 1'b0;
        ev_phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && core_ev.valid) begin
      ev <= core_ev;
    end
  end

  assign tick_out = (ev.two && ev_phase) ? ev.tick1 : ev.tick0;
  assign lto_out  = ev.two ? !ev_phase : !ev.single_ht;
  assign ht_out   = ev.two ? ev_phase : ev.single_ht;

  assign m_tvalid = ev_valid;
  assign m_tlast  = !ev.two || ev_phase;
  assign m_tdata  = {{(M_DATA_W - TICK_W - 4 - WNUM_W){1'b0}}, ev.wnum,
                     cfg.spare_enable, cfg.xt_enable, ht_out, lto_out, tick_out};

  `DTT_ASSERT_SAME(a_phase_two, ev_valid && ev_phase, ev.two, "second phase without pair")
  `DTT_ASSERT_NEXT(a_second_ht, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast && ht_out && !lto_out, "pair not closed by HT item")
  `DTT_ASSERT_SAME(a_stall_cause, a_valid && !s_tready, ev_valid, "input stalled with free output")

endmodule
